/* design/mcgp_pkg.sv */
package mcgp_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 64;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int NR_W       = ROW_W + 1;
    localparam int NC_W       = COL_W + 1;
    localparam int W_W        = 16;
    localparam int COST_W     = 22;
    localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int COST_DEPTH = 2 * MAX_ROWS;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int ODATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 8'd1;

    // candidate rows of the next column, in order of evaluation
    localparam logic [1:0] CAND_UP  = 2'd0;
    localparam logic [1:0] CAND_MID = 2'd1;
    localparam logic [1:0] CAND_DN  = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_E_INIT,
        ST_E_SHOW,
        ST_E_FETCH
    } t_state;

    typedef struct packed {
        logic       load_wr;
        logic       solve_init;
        logic [1:0] k;
        logic       first;
        logic       eval;
        logic       w_live;
        logic       cap_w;
        logic       commit;
        logic       emit_init;
        logic       emit_next;
    } t_cmd;

    typedef struct packed {
        logic last_load;
        logic lastcol;
        logic last_cell;
        logic emit_last;
    } t_stat;

endpackage

/* design/mcgp_ram.sv */
module mcgp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/mcgp_ctrl.sv */
module mcgp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  mcgp_pkg::t_stat i_stat,
    output mcgp_pkg::t_cmd  o_cmd
);
    import mcgp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid && !i_cfg_valid && i_stat.last_load) begin
                    n_state = ST_P0;
                end
            end
            ST_P0: begin
                n_state = i_stat.lastcol ? ST_P3 : ST_P1;
            end
            ST_P1: n_state = ST_P2;
            ST_P2: n_state = ST_P3;
            ST_P3: begin
                n_state = i_stat.last_cell ? ST_E_INIT : ST_P0;
            end
            ST_E_INIT: n_state = ST_E_SHOW;
            ST_E_SHOW: begin
                if (i_out_ready) begin
                    n_state = i_stat.emit_last ? ST_LOAD : ST_E_FETCH;
                end
            end
            ST_E_FETCH: n_state = ST_E_SHOW;
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.k     = CAND_UP;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            ST_LOAD: begin
                // a register write wins over a cell in the same cycle
                o_cfg_ready      = 1'b1;
                o_in_ready       = !i_cfg_valid;
                o_cmd.load_wr    = i_in_valid && !i_cfg_valid;
                o_cmd.solve_init = i_in_valid && !i_cfg_valid && i_stat.last_load;
            end
            ST_P0: begin
                o_cmd.k = CAND_UP;
            end
            ST_P1: begin
                o_cmd.eval   = 1'b1;
                o_cmd.first  = 1'b1;
                o_cmd.w_live = 1'b1;
                o_cmd.cap_w  = 1'b1;
                o_cmd.k      = CAND_MID;
            end
            ST_P2: begin
                o_cmd.eval = 1'b1;
                o_cmd.k    = CAND_DN;
            end
            ST_P3: begin
                o_cmd.eval   = 1'b1;
                o_cmd.commit = 1'b1;
                o_cmd.w_live = i_stat.lastcol;
            end
            ST_E_INIT: begin
                o_cmd.emit_init = 1'b1;
            end
            ST_E_SHOW: begin
                o_out_valid = 1'b1;
            end
            ST_E_FETCH: begin
                o_cmd.emit_next = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* design/mcgp_dp.sv */
module mcgp_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr,
    input  logic [mcgp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mcgp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [mcgp_pkg::W_W-1:0]        i_weight,
    input  mcgp_pkg::t_cmd                  i_cmd,
    output mcgp_pkg::t_stat                 o_stat,
    output logic [mcgp_pkg::ROW_W-1:0]      o_path_row,
    output logic [mcgp_pkg::COST_W-1:0]     o_path_cost
);
    import mcgp_pkg::*;

    localparam int GRID_AW = $clog2(GRID_DEPTH);
    localparam int COST_AW = $clog2(COST_DEPTH);

    // configuration and load position
    logic [NR_W-1:0]  r_rows;
    logic [NC_W-1:0]  r_cols;
    logic [ROW_W-1:0] r_load_row, n_load_row;
    logic [COL_W-1:0] r_load_col, n_load_col;
    logic [NR_W-1:0]  nr;
    logic [NC_W-1:0]  nc;
    logic [ROW_W-1:0] eff_row;
    logic [COL_W-1:0] eff_col;
    logic             load_wrap;

    // solve position and accumulator
    logic [ROW_W-1:0]         r_r;
    logic [COL_W-1:0]         r_c;
    logic signed [W_W-1:0]    r_w;
    logic [ROW_W-1:0]         r_cand;
    logic signed [COST_W-1:0] r_v;
    logic [ROW_W-1:0]         r_pick;
    logic signed [COST_W-1:0] r_best;
    logic [ROW_W-1:0]         r_start;
    logic                     r_best_first;
    logic [ROW_W-1:0]         r_erow;
    logic [COL_W-1:0]         r_ecol;

    logic [ROW_W-1:0]         last_row;
    logic                     row_end;
    logic [ROW_W-1:0]         cand_issue;
    logic signed [W_W-1:0]    w_cur;
    logic signed [COST_W-1:0] w_ext;
    logic signed [COST_W-1:0] s;
    logic                     better;
    logic signed [COST_W-1:0] n_v;
    logic [ROW_W-1:0]         n_pick;
    logic signed [COST_W-1:0] commit_val;

    logic [W_W-1:0]    grid_rd;
    logic [COST_W-1:0] cost_rd;
    logic [ROW_W-1:0]  choice_rd;

    // size clamp: zero counts as one, oversize counts as the maximum
    always_comb begin
        if (r_rows == '0) begin
            nr = NR_W'(1);
        end else if (r_rows > NR_W'(MAX_ROWS)) begin
            nr = NR_W'(MAX_ROWS);
        end else begin
            nr = r_rows;
        end
        if (r_cols == '0) begin
            nc = NC_W'(1);
        end else if (r_cols > NC_W'(MAX_COLS)) begin
            nc = NC_W'(MAX_COLS);
        end else begin
            nc = r_cols;
        end
    end

    // load address, restarted when it lies outside the current grid
    always_comb begin
        load_wrap = ({1'b0, r_load_row} >= nr) || ({1'b0, r_load_col} >= nc);
        eff_row   = load_wrap ? '0 : r_load_row;
        eff_col   = load_wrap ? '0 : r_load_col;
        if (({1'b0, eff_col} + NC_W'(1)) < nc) begin
            n_load_col = eff_col + COL_W'(1);
            n_load_row = eff_row;
        end else begin
            n_load_col = '0;
            if (({1'b0, eff_row} + NR_W'(1)) < nr) begin
                n_load_row = eff_row + ROW_W'(1);
            end else begin
                n_load_row = '0;
            end
        end
    end

    assign last_row = ROW_W'(nr - NR_W'(1));
    assign row_end  = (r_r == last_row);

    // neighbor rows with wrap-around between top and bottom
    always_comb begin
        case (i_cmd.k)
            CAND_UP:  cand_issue = (r_r == '0) ? last_row : r_r - ROW_W'(1);
            CAND_MID: cand_issue = r_r;
            CAND_DN:  cand_issue = row_end ? '0 : r_r + ROW_W'(1);
            default:  cand_issue = r_r;
        endcase
    end

    // candidate evaluation; ties go to the smaller row
    always_comb begin
        w_cur  = i_cmd.w_live ? $signed(grid_rd) : r_w;
        w_ext  = COST_W'(w_cur);
        s      = $signed(cost_rd) + w_ext;
        better = i_cmd.first || (s < r_v) || ((s == r_v) && (r_cand < r_pick));
        n_v    = better ? s : r_v;
        n_pick = better ? r_cand : r_pick;
        commit_val = o_stat.lastcol ? w_ext : n_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= NR_W'(1);
            r_cols       <= NC_W'(1);
            r_load_row   <= '0;
            r_load_col   <= '0;
            r_best       <= '0;
            r_start      <= '0;
            r_best_first <= 1'b1;
        end else begin
            if (i_cfg_wr && (i_cfg_index == CFG_ROWS)) begin
                r_rows     <= i_cfg_data[NR_W-1:0];
                r_load_row <= '0;
                r_load_col <= '0;
            end else if (i_cfg_wr && (i_cfg_index == CFG_COLS)) begin
                r_cols     <= i_cfg_data[NC_W-1:0];
                r_load_row <= '0;
                r_load_col <= '0;
            end else if (i_cmd.load_wr) begin
                r_load_row <= n_load_row;
                r_load_col <= n_load_col;
            end
            if (i_cmd.solve_init) begin
                r_best_first <= 1'b1;
            end else if (i_cmd.commit && (r_c == '0)) begin
                r_best_first <= 1'b0;
                if (r_best_first || (commit_val < r_best)) begin
                    r_best  <= commit_val;
                    r_start <= r_r;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cand <= cand_issue;
        if (i_cmd.cap_w) begin
            r_w <= $signed(grid_rd);
        end
        if (i_cmd.eval) begin
            r_v    <= n_v;
            r_pick <= n_pick;
        end
        if (i_cmd.solve_init) begin
            r_r <= '0;
            r_c <= COL_W'(nc - NC_W'(1));
        end else if (i_cmd.commit) begin
            if (row_end) begin
                r_r <= '0;
                r_c <= r_c - COL_W'(1);
            end else begin
                r_r <= r_r + ROW_W'(1);
            end
        end
        if (i_cmd.emit_init) begin
            r_erow <= r_start;
            r_ecol <= '0;
        end else if (i_cmd.emit_next) begin
            r_erow <= choice_rd;
            r_ecol <= r_ecol + COL_W'(1);
        end
    end

    mcgp_ram #(.WIDTH(W_W), .DEPTH(GRID_DEPTH)) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load_wr),
        .i_wr_addr ({eff_row, eff_col}),
        .i_wr_data (i_weight),
        .i_rd_addr ({r_r, r_c}),
        .o_rd_data (grid_rd)
    );

    // two banks: the column being solved and the one to its right
    mcgp_ram #(.WIDTH(COST_W), .DEPTH(COST_DEPTH)) u_cost (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit),
        .i_wr_addr (COST_AW'({r_c[0], r_r})),
        .i_wr_data (commit_val),
        .i_rd_addr (COST_AW'({~r_c[0], cand_issue})),
        .o_rd_data (cost_rd)
    );

    mcgp_ram #(.WIDTH(ROW_W), .DEPTH(GRID_DEPTH)) u_choice (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit && !o_stat.lastcol),
        .i_wr_addr (GRID_AW'({r_c, r_r})),
        .i_wr_data (n_pick),
        .i_rd_addr (GRID_AW'({r_ecol, r_erow})),
        .o_rd_data (choice_rd)
    );

    always_comb begin
        o_stat.last_load = (eff_row == last_row) && ({1'b0, eff_col} == nc - NC_W'(1));
        o_stat.lastcol   = ({1'b0, r_c} == nc - NC_W'(1));
        o_stat.last_cell = row_end && (r_c == '0);
        o_stat.emit_last = ({1'b0, r_ecol} == nc - NC_W'(1));
    end

    assign o_path_row  = r_erow;
    assign o_path_cost = r_best;

endmodule

/* design/min_cost_grid_path_wrap.sv */
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[15:0] cell_weight
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[3:0] path_row, [25:4] path_cost;
//                                             tlast path_end
// cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// Loading accepts a cell whenever no register write is offered. The solve steps through
// P0 to P3 per cell (only P0 and P3 in the rightmost column): one cost memory read port
// serves the three neighbor reads of a cell. Emission shows each result item, then fetches
// the next row choice. Reset is synchronous and active low; the memories are not cleared.
// The input stalls from the last cell until the final result item is taken, and while a
// register write is offered (writes land only while loading); a stalled result holds.
module min_cost_grid_path_wrap (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mcgp_pkg::W_W-1:0]        s_axis_tdata,   // [15:0] cell_weight
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mcgp_pkg::ODATA_W-1:0]    m_axis_tdata,   // [3:0] path_row, [25:4] path_cost
    output logic                            m_axis_tlast,   // path_end
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mcgp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mcgp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mcgp_pkg::*;

    t_cmd                cmd;
    t_stat               stat;
    logic [ROW_W-1:0]    path_row;
    logic [COST_W-1:0]   path_cost;

    mcgp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // registers take writes only while loading, so a solve never sees a size change
    mcgp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_weight    (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_path_row  (path_row),
        .o_path_cost (path_cost)
    );

    // pack row then cost, pad to whole bytes
    assign m_axis_tdata = {{(ODATA_W - ROW_W - COST_W){1'b0}}, path_cost, path_row};
    assign m_axis_tlast = stat.emit_last;

endmodule

/* design/mcgp_chk.sv */
module mcgp_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mcgp_pkg::ODATA_W-1:0]    m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready
);
    import mcgp_pkg::*;

    logic out_acc;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result item changed while stalled");

    // no cell is taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is shown");

    // the path total is the same on every item of one path
    a_cost_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !m_axis_tlast) |=>
        (!s_axis_tready && $stable(m_axis_tdata[ROW_W+COST_W-1:ROW_W])))
        else $error("path cost changed within one path");

    // loading resumes right after the final item
    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && m_axis_tlast) |=> (o_cfg_ready && !m_axis_tvalid))
        else $error("loading did not resume after the final item");

    // a register write lands only while loading and never beside a cell
    a_cfg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> (!s_axis_tready && !m_axis_tvalid))
        else $error("register write outside loading or beside a cell");

endmodule

bind min_cost_grid_path_wrap mcgp_chk u_chk (.*);
